@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the codec RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

@@ src/zvc_pkg.sv @@
// ---------------------------------------------------------------------------
// Zigzag varint codec package
// Shared constants, the direction code and the inter-module structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zvc_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int BYTE_BITS      = 8;
  localparam int GROUP_BITS     = 7;
  localparam int SHIFT_BITS     = 6;
  localparam int VALUE_MIN_BITS = 8;
  localparam int VALUE_MAX_BITS = FIELD_BITS;

  localparam logic [SHIFT_BITS-1:0] SHIFT_MAX  = 6'd63;
  localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'h7F;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } direction_t;

  typedef struct packed {
    logic                 valid;
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } enc_emit_t;

  typedef struct packed {
    logic                         done;
    logic signed [FIELD_BITS-1:0] value;
    logic                         overflow;
  } dec_result_t;

endpackage

`default_nettype wire

@@ src/zvc_encoder.sv @@
// ---------------------------------------------------------------------------
// Zigzag varint encoder
// Zigzag-maps a value into a shift register and emits one 7-bit group per
// cycle while advance is high, least significant first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module zvc_encoder
  import zvc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic signed [FIELD_BITS-1:0] value,
  input  logic                         advance,
  output enc_emit_t                    emit
);

  logic [VALUE_WIDTH-1:0] sreg;
  logic                   active;
  logic [VALUE_WIDTH-1:0] x;
  logic [VALUE_WIDTH-1:0] zig;
  logic                   more;

  assign x    = value[VALUE_WIDTH-1:0];
  assign zig  = {x[VALUE_WIDTH-2:0], 1'b0} ^ {VALUE_WIDTH{x[VALUE_WIDTH-1]}};
  assign more = |sreg[VALUE_WIDTH-1:GROUP_BITS];

  assign emit.valid = active;
  assign emit.data  = {more, sreg[GROUP_BITS-1:0] & GROUP_MASK};
  assign emit.last  = !more;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (active && advance && !more) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sreg <= zig;
    end else if (active && advance) begin
      sreg <= sreg >> GROUP_BITS;
    end
  end

  `ASSERT_IMPLIES(a_load_when_free, clk, rst, load |-> (!active || (advance && !more)))
  `ASSERT_IMPLIES(a_shift_drains, clk, rst, (active && advance && more && !load) |=> active)
  `ASSERT_IMPLIES(a_load_starts, clk, rst, load |=> (active && $past(zig) == sreg))

endmodule

`default_nettype wire

@@ src/zvc_decoder.sv @@
// ---------------------------------------------------------------------------
// Zigzag varint decoder
// Merges one 7-bit group per byte into the accumulator and un-zigzags the
// value on the closing byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module zvc_decoder
  import zvc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 step,
  input  logic [BYTE_BITS-1:0] byte_in,
  output dec_result_t          result
);

  localparam int PART_WIDTH = VALUE_WIDTH + GROUP_BITS;

  logic [VALUE_WIDTH-1:0] accumulator;
  logic [SHIFT_BITS-1:0]  group_shift;
  logic                   lost_bits;

  logic [VALUE_WIDTH-1:0] accumulator_next;
  logic [SHIFT_BITS-1:0]  group_shift_next;
  logic                   lost_bits_next;

  logic [GROUP_BITS-1:0]  group;
  logic                   in_range;
  logic [PART_WIDTH-1:0]  part;
  logic [SHIFT_BITS:0]    shift_sum;
  logic [VALUE_WIDTH-1:0] unzig;
  logic signed [VALUE_WIDTH-1:0] unzig_s;

  assign group     = byte_in[GROUP_BITS-1:0];
  assign in_range  = group_shift < SHIFT_BITS'(VALUE_WIDTH);
  assign part      = PART_WIDTH'(group) << group_shift;
  assign shift_sum = {1'b0, group_shift} + (SHIFT_BITS + 1)'(GROUP_BITS);

  always_comb begin
    if (in_range) begin
      accumulator_next = accumulator | part[VALUE_WIDTH-1:0];
      lost_bits_next   = lost_bits | (|part[PART_WIDTH-1:VALUE_WIDTH]);
    end else begin
      accumulator_next = accumulator;
      lost_bits_next   = lost_bits | (|group);
    end
    group_shift_next = shift_sum[SHIFT_BITS] ? SHIFT_MAX : shift_sum[SHIFT_BITS-1:0];
  end

  assign unzig   = (accumulator_next >> 1) ^ {VALUE_WIDTH{accumulator_next[0]}};
  assign unzig_s = signed'(unzig);

  assign result.done     = step && !byte_in[BYTE_BITS-1];
  assign result.value    = FIELD_BITS'(unzig_s);
  assign result.overflow = lost_bits_next;

  always_ff @(posedge clk) begin
    if (rst || clear || result.done) begin
      accumulator <= '0;
      group_shift <= '0;
      lost_bits   <= 1'b0;
    end else if (step) begin
      accumulator <= accumulator_next;
      group_shift <= group_shift_next;
      lost_bits   <= lost_bits_next;
    end
  end

  `ASSERT_IMPLIES(a_done_clears, clk, rst, result.done |=> (group_shift == '0 && !lost_bits))
  `ASSERT_IMPLIES(a_shift_advances, clk, rst,
    (step && byte_in[BYTE_BITS-1] && !clear) |=> group_shift != '0)
  `ASSERT_IMPLIES(a_lost_sticks, clk, rst,
    (lost_bits && !step && !clear) |=> lost_bits)

endmodule

`default_nettype wire

@@ src/zigzag_varint_codec_core.sv @@
// ---------------------------------------------------------------------------
// Zigzag varint codec core
// Encodes signed values into varint bytes or decodes bytes into values,
// selected by the direction register.
// ---------------------------------------------------------------------------
// Channel  Payload                               Handshake
// input    value_in (encode), byte_in (decode)   in_valid / in_ready
// output   byte_out, value_out, overflow, last   out_valid / out_ready
// config   cfg_wdata (direction)                 cfg_we
//
// Encode: a value yields one byte per cycle unless the output stalls, one per
// 7-bit group of the shift register; the next value is taken with the last byte.
// Decode: one byte per cycle; a value appears in the cycle after its final byte.
// Reset clears the direction to encode and empties the decode state.
// A stalled output holds its register; decode then takes no bytes, and encode
// takes at most one further value, which waits in the shift register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module zigzag_varint_codec_core
  import zvc_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [FIELD_BITS-1:0] value_in,
  input  logic [BYTE_BITS-1:0]         byte_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [BYTE_BITS-1:0]         byte_out,
  output logic signed [FIELD_BITS-1:0] value_out,
  output logic                         overflow,
  output logic                         last
);

  localparam int VALUE_WIDTH = (VALUE_BITS < VALUE_MIN_BITS) ? VALUE_MIN_BITS :
                               (VALUE_BITS > VALUE_MAX_BITS) ? VALUE_MAX_BITS : VALUE_BITS;

  direction_t  direction;
  enc_emit_t   emit;
  dec_result_t result;
  logic        out_free;
  logic        in_take;
  logic        enc_load;
  logic        enc_take;
  logic        dec_step;

  assign out_free = !out_valid || out_ready;
  assign enc_take = (direction == DIR_ENCODE) && emit.valid && out_free;

  always_comb begin
    unique case (direction)
      DIR_ENCODE: in_ready = !emit.valid || (enc_take && emit.last);
      DIR_DECODE: in_ready = out_free;
      default:    in_ready = 1'b0;
    endcase
  end

  assign in_take  = in_valid && in_ready;
  assign enc_load = in_take && (direction == DIR_ENCODE);
  assign dec_step = in_take && (direction == DIR_DECODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_we) begin
      direction <= direction_t'(cfg_wdata);
    end
  end

  zvc_encoder #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_encoder (
    .clk     (clk),
    .rst     (rst),
    .load    (enc_load),
    .value   (value_in),
    .advance (enc_take),
    .emit    (emit)
  );

  zvc_decoder #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_decoder (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_we),
    .step    (dec_step),
    .byte_in (byte_in),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enc_take || result.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_take) begin
      byte_out  <= emit.data;
      value_out <= '0;
      overflow  <= 1'b0;
      last      <= emit.last;
    end else if (result.done) begin
      byte_out  <= '0;
      value_out <= result.value;
      overflow  <= result.overflow;
      last      <= 1'b1;
    end
  end

  `ASSERT_IMPLIES(a_last_marks_end, clk, rst, out_valid |-> (last != byte_out[BYTE_BITS-1]))
  `ASSERT_IMPLIES(a_decode_result, clk, rst,
    (dec_step && !byte_in[BYTE_BITS-1]) |=> (out_valid && last && byte_out == '0))
  `ASSERT_NEVER(a_no_overwrite, clk, rst, (enc_take || result.done) && out_valid && !out_ready)

endmodule

`default_nettype wire

@@ tb/tb_zigzag_varint_codec_core.sv @@
// ---------------------------------------------------------------------------
// Testbench for the zigzag varint codec core
// Drives values and bytes through the codec in both directions and checks
// every output transfer against a predictor of the zigzag and varint rules,
// over directed corner cases and random traffic under varied flow control.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_zigzag_varint_codec_core;
  import zvc_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 60;

  typedef struct packed {
    logic [BYTE_BITS-1:0]         data_byte;
    logic signed [FIELD_BITS-1:0] value;
    logic                         overflow;
    logic                         last;
  } codec_result_t;

  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         cfg_we     = 1'b0;
  logic                         cfg_wdata  = 1'b0;
  logic                         in_valid   = 1'b0;
  logic signed [FIELD_BITS-1:0] value_in   = '0;
  logic [BYTE_BITS-1:0]         byte_in    = '0;
  logic                         out_ready  = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [BYTE_BITS-1:0]         byte_out;
  logic signed [FIELD_BITS-1:0] value_out;
  logic                         overflow;
  logic                         last;

  direction_t                   model_direction = DIR_ENCODE;
  logic [FIELD_BITS-1:0]        model_acc       = '0;
  logic [SHIFT_BITS-1:0]        model_shift     = '0;
  logic                         model_lost      = 1'b0;
  codec_result_t                expected_results[$];

  int errors         = 0;
  int n_values       = 0;
  int n_bytes        = 0;
  int n_results      = 0;
  int n_overflows    = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  zigzag_varint_codec_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value_in  (value_in),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte_out  (byte_out),
    .value_out (value_out),
    .overflow  (overflow),
    .last      (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_decode_state();
    model_acc   = '0;
    model_shift = '0;
    model_lost  = 1'b0;
  endfunction

  function automatic void queue_result(codec_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_encoded_bytes(logic signed [FIELD_BITS-1:0] v);
    logic [FIELD_BITS-1:0] code;
    int                    k;
    code = {v[FIELD_BITS-2:0], 1'b0} ^ {FIELD_BITS{v[FIELD_BITS-1]}};
    k    = 0;
    while (code > 32'h7F && k < 4) begin
      queue_result(codec_result_t'{{1'b1, code[6:0]}, '0, 1'b0, 1'b0});
      code = code >> GROUP_BITS;
      k++;
    end
    queue_result(codec_result_t'{code[7:0], '0, 1'b0, 1'b1});
  endfunction

  function automatic void predict_decoded_value(logic [BYTE_BITS-1:0] b);
    logic [GROUP_BITS-1:0] grp;
    logic [63:0]           part;
    logic [SHIFT_BITS:0]   next_shift;
    logic [FIELD_BITS-1:0] v;
    grp = b[GROUP_BITS-1:0] & GROUP_MASK;
    if (model_shift >= FIELD_BITS) begin
      if (grp != 0) model_lost = 1'b1;
    end else begin
      part = {57'd0, grp} << model_shift;
      if (part[63:FIELD_BITS] != 0) model_lost = 1'b1;
      model_acc = model_acc | part[FIELD_BITS-1:0];
    end
    next_shift  = {1'b0, model_shift} + (SHIFT_BITS + 1)'(GROUP_BITS);
    model_shift = (next_shift > {1'b0, SHIFT_MAX}) ? SHIFT_MAX : next_shift[SHIFT_BITS-1:0];
    if (!b[7]) begin
      v = (model_acc >> 1) ^ {FIELD_BITS{model_acc[0]}};
      queue_result(codec_result_t'{'0, v, model_lost, 1'b1});
      clear_decode_state();
    end
  endfunction

  always @(posedge clk) begin
    codec_result_t got, want;
    if (!rst) begin
      if (cfg_we) begin
        model_direction = direction_t'(cfg_wdata);
        clear_decode_state();
      end
      if (in_valid && in_ready) begin
        if (model_direction == DIR_ENCODE) begin
          predict_encoded_bytes(value_in);
          n_values++;
        end else begin
          predict_decoded_value(byte_in);
          n_bytes++;
        end
      end
      if (out_valid && out_ready) begin
        got = '{byte_out, value_out, overflow, last};
        n_results++;
        if (got.overflow) n_overflows++;
        if (expected_results.size() == 0) begin
          $error("unexpected transfer: byte_out %0h, value_out %0d, overflow %0b, last %0b",
                 got.data_byte, got.value, got.overflow, got.last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.data_byte !== want.data_byte) begin
            $error("byte_out: expected %0h, actual %0h", want.data_byte, got.data_byte);
            errors++;
          end
          if (got.value !== want.value) begin
            $error("value_out: expected %0d, actual %0d", want.value, got.value);
            errors++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_zigzag_varint_codec_core: done, errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input logic signed [FIELD_BITS-1:0] v,
                           input logic [BYTE_BITS-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    value_in = v;
    byte_in  = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_value(input logic signed [FIELD_BITS-1:0] v);
    send_item(v, BYTE_BITS'($urandom_range(255)));
  endtask

  task automatic send_byte(input logic [BYTE_BITS-1:0] b);
    send_item($urandom, b);
  endtask

  // Waits until every expected transfer has arrived and the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_direction(input direction_t d);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = d;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic send_decode_sequence(input int len, input bit well_formed);
    logic [GROUP_BITS-1:0] grp;
    logic                  more;
    for (int i = 0; i < len; i++) begin
      grp  = GROUP_BITS'($urandom_range(127));
      more = (i != len - 1);
      if (well_formed && i == 4) grp = GROUP_BITS'($urandom_range(15));
      send_byte({more, grp});
    end
  endtask

  function automatic logic signed [FIELD_BITS-1:0] random_value();
    logic signed [FIELD_BITS-1:0] v;
    v = $urandom;
    case ($urandom_range(11))
      0: v = 32'sh7FFFFFFF;
      1: v = 32'sh80000000;
      2: v = '0;
      default: v = v >>> $urandom_range(31);
    endcase
    return v;
  endfunction

  task automatic test_encode_edges();
    logic [FIELD_BITS-1:0] edge_vals [8] = '{32'h0, 32'hFFFFFFFF, 32'h3F, 32'hFFFFFFC0,
                                              32'h40, 32'h2000, 32'h7FFFFFFF, 32'h80000000};
    write_direction(DIR_ENCODE);
    foreach (edge_vals[i]) send_value(edge_vals[i]);
  endtask

  task automatic test_decode_edges();
    write_direction(DIR_DECODE);
    send_byte(8'h7F);
    // The most negative value, five bytes long.
    repeat (4) send_byte(8'hFF);
    send_byte(8'h0F);
    // An overlong value that drops bits and drives the shift into saturation.
    repeat (10) send_byte(8'hFF);
    send_byte(8'h01);
  endtask

  task automatic test_direction_clear();
    send_byte(8'h85);
    write_direction(DIR_DECODE);
    send_byte(8'h01);
    write_direction(DIR_ENCODE);
    send_value(32'sd5);
  endtask

  task automatic run_random_phase(input int n_items);
    int sent;
    int block;
    int count;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      block = $urandom_range(4, 14);
      if ($urandom_range(1) == 0) begin
        write_direction(DIR_ENCODE);
        repeat (block) send_value(random_value());
        sent += block;
      end else begin
        write_direction(DIR_DECODE);
        count = 0;
        while (count < block) begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            len = $urandom_range(1, 5);
            send_decode_sequence(len, 1'b1);
          end else if (pick < 85) begin
            len = $urandom_range(6, 12);
            send_decode_sequence(len, 1'b0);
          end else begin
            len = 1;
            send_byte(BYTE_BITS'($urandom_range(255)));
          end
          count += len;
        end
        sent += count;
      end
    end
  endtask

  task automatic test_random_traffic();
    int idle_pct  [4] = '{0, 47, 0, 14};
    int stall_pct [4] = '{0, 0, 47, 14};
    for (int p = 0; p < 4; p++) begin
      settle();
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      run_random_phase(ITEMS_PER_PHASE);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_encode_edges();
    test_decode_edges();
    test_direction_clear();
    test_random_traffic();
    settle();
    $display("Covered %0d encoded values and %0d decoded bytes, %0d output transfers checked.",
             n_values, n_bytes, n_results);
    $display("Decoded values with overflow: %0d; %s", n_overflows,
             "traffic ran free, sender-, receiver- and both-throttled.");
    if (errors == 0) begin
      $display("tb_zigzag_varint_codec_core: done, clean");
    end else begin
      $display("tb_zigzag_varint_codec_core: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/zvc_pkg.sv
src/zvc_encoder.sv
src/zvc_decoder.sv
src/zigzag_varint_codec_core.sv
tb/tb_zigzag_varint_codec_core.sv
